[hw/rtl/harp_pkg.sv]
// Shared types, codes and the haptic sample scaler for the report patcher.
package harp_pkg;

	localparam int unsigned MAX_REPORT_BYTES = 1024;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = 2;
	localparam int unsigned CNT_W      = 3;

	localparam logic [2:0] REG_AUDIO_MODE  = 3'd0;
	localparam logic [2:0] REG_LATENCY     = 3'd1;
	localparam logic [2:0] REG_HEADSET_VOL = 3'd2;
	localparam logic [2:0] REG_SPEAKER_VOL = 3'd3;
	localparam logic [2:0] REG_HAPTIC_GAIN = 3'd4;

	localparam logic [2:0] MODE_AUTO    = 3'd0;
	localparam logic [2:0] MODE_SPEAKER = 3'd2;
	localparam logic [2:0] MODE_HEADSET = 3'd3;
	localparam logic [2:0] MODE_BOTH    = 3'd4;

	localparam logic [7:0] TYPE_A = 8'h36;
	localparam logic [7:0] TYPE_B = 8'h32;
	localparam logic [7:0] TYPE_C = 8'h39;

	localparam logic [7:0] ID_FLAGS      = 8'h90;
	localparam logic [7:0] ID_LATENCY    = 8'h91;
	localparam logic [7:0] ID_HAPTIC     = 8'h92;
	localparam logic [7:0] ROUTE_SPEAKER = 8'h93;
	localparam logic [7:0] ROUTE_BOTH    = 8'h95;
	localparam logic [7:0] ROUTE_HEADSET = 8'h96;
	localparam logic [7:0] ID_DOUBLE     = 8'h40;
	localparam logic [7:0] ID_BASE_MASK  = 8'hbf;

	localparam logic [7:0] FLAGS_AUTO  = 8'h30;
	localparam logic [7:0] FLAGS_FORCE = 8'hb0;
	localparam logic [7:0] FLAGS_HI    = 8'h80;
	localparam logic [7:0] FLAGS_SPK   = 8'h30;
	localparam logic [7:0] VOL_MAX     = 8'h64;

	localparam logic [10:0] GAIN_UNITY = 11'd256;
	localparam logic [10:0] GAIN_MAX   = 11'd1280;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       changed;
	} harp_word_t;

	typedef struct packed {
		logic       en0;
		harp_word_t w0;
		logic       en1;
		harp_word_t w1;
	} harp_push_t;

	// signed sample times Q3.8 gain, round half even, saturate
	function automatic logic [7:0] scale_sample(input logic [7:0] b, input logic [10:0] gain);
		logic [10:0] g;
		logic [7:0]  mag;
		logic [18:0] prod;
		logic [10:0] q;
		logic        rnd;
		g    = (gain > GAIN_MAX) ? GAIN_MAX : gain;
		mag  = b[7] ? 8'(9'd256 - {1'b0, b}) : b;
		prod = 19'(mag) * 19'(g);
		q    = {1'b0, prod[17:8]};
		rnd  = (prod[7:0] > 8'd128) || ((prod[7:0] == 8'd128) && q[0]);
		q    = q + 11'(rnd);
		if (b[7]) begin
			if (q > 11'd128) q = 11'd128;
			return 8'(9'd256 - q[8:0]);
		end
		if (q > 11'd127) q = 11'd127;
		return q[7:0];
	endfunction

endpackage

[hw/rtl/hid_audio_report_patcher.sv]
// Audio output report patcher: sub-block walk, byte rewrite and output queue.
//
// One report byte is taken per cycle when in_ready is high. Each byte is
// decided in the cycle it is accepted and held back by one byte, so a route id
// can be rewritten after its length byte; the final byte of a report releases
// two words at once and the first byte of a report releases none. Words go to
// a four-entry queue, and in_ready is high while that queue has at least two
// free entries, so with out_ready held high the block sustains one byte per
// cycle. Configuration writes take effect on the next byte.
module hid_audio_report_patcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic [10:0] report_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic        last_out,
	output logic        report_changed,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [10:0] wr_data
);

	logic [2:0]  audio_mode_q;
	logic [7:0]  latency_q;
	logic [7:0]  headset_vol_q;
	logic [7:0]  speaker_vol_q;
	logic [10:0] haptic_gain_q;

	logic [7:0]  held_byte_q;
	logic        held_valid_q;
	logic [11:0] pos_q;
	logic        patchable_q;
	logic        stopped_q;
	logic [8:0]  off_q;
	logic [9:0]  blen_q;
	logic [7:0]  id_q;
	logic [7:0]  plen_q;
	logic        changed_q;

	logic        patchable_n;
	logic        stopped_n;
	logic [8:0]  off_n;
	logic [9:0]  blen_n;
	logic [7:0]  id_n;
	logic [7:0]  plen_n;
	logic        changed_n;
	logic [7:0]  b_n;
	logic [7:0]  held_out;

	logic        accept;
	logic [12:0] pos13;
	logic [12:0] limit13;
	logic [9:0]  blen;
	logic [7:0]  base;
	logic [7:0]  route;
	logic [7:0]  routed;
	logic [7:0]  nb;
	logic        autom;
	logic [7:0]  lat;
	logic [7:0]  hv;
	logic [7:0]  sv;
	logic        hs_on;
	logic        sp_on;

	harp_pkg::harp_push_t push;
	harp_pkg::harp_word_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_mode_q  <= harp_pkg::MODE_AUTO;
			latency_q     <= 8'd20;
			headset_vol_q <= 8'd100;
			speaker_vol_q <= 8'd100;
			haptic_gain_q <= harp_pkg::GAIN_UNITY;
		end else if (wr_en) begin
			unique case (wr_index)
				harp_pkg::REG_AUDIO_MODE:  audio_mode_q  <= wr_data[2:0];
				harp_pkg::REG_LATENCY:     latency_q     <= wr_data[7:0];
				harp_pkg::REG_HEADSET_VOL: headset_vol_q <= wr_data[7:0];
				harp_pkg::REG_SPEAKER_VOL: speaker_vol_q <= wr_data[7:0];
				harp_pkg::REG_HAPTIC_GAIN: haptic_gain_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign accept  = in_valid && in_ready;
	assign pos13   = {1'b0, pos_q};
	assign limit13 = (report_length >= 11'd4) ? 13'(report_length - 11'd4) : '0;
	assign base    = id_q & harp_pkg::ID_BASE_MASK;
	assign autom   = audio_mode_q == harp_pkg::MODE_AUTO;
	assign lat     = (latency_q == 8'd0) ? 8'd1 : latency_q;
	assign hv      = (headset_vol_q > harp_pkg::VOL_MAX) ? harp_pkg::VOL_MAX : headset_vol_q;
	assign sv      = (speaker_vol_q > harp_pkg::VOL_MAX) ? harp_pkg::VOL_MAX : speaker_vol_q;
	assign hs_on   = (audio_mode_q == harp_pkg::MODE_HEADSET) ||
	                 (audio_mode_q == harp_pkg::MODE_BOTH);
	assign sp_on   = (audio_mode_q == harp_pkg::MODE_SPEAKER) ||
	                 (audio_mode_q == harp_pkg::MODE_BOTH);
	assign blen    = (id_q[6] ? {1'b0, byte_value, 1'b0} : {2'b0, byte_value}) + 10'd2;
	assign routed  = route | (id_q & harp_pkg::ID_DOUBLE);

	always_comb begin
		unique case (audio_mode_q)
			harp_pkg::MODE_SPEAKER: route = harp_pkg::ROUTE_SPEAKER;
			harp_pkg::MODE_HEADSET: route = harp_pkg::ROUTE_HEADSET;
			harp_pkg::MODE_BOTH:    route = harp_pkg::ROUTE_BOTH;
			default:                route = 8'd0;
		endcase
	end

	// payload byte rewrite, offset counted from the block id
	always_comb begin
		nb = byte_value;
		if (base == harp_pkg::ID_FLAGS && plen_q >= 8'd8) begin
			if (autom) begin
				case (off_q)
					9'd2:    nb = byte_value | harp_pkg::FLAGS_AUTO;
					9'd6:    nb = hv;
					9'd7:    nb = sv;
					default: nb = byte_value;
				endcase
			end else begin
				case (off_q)
					9'd2:    nb = byte_value | harp_pkg::FLAGS_FORCE;
					9'd3:    nb = byte_value | harp_pkg::FLAGS_HI;
					9'd6:    nb = hs_on ? hv : 8'd0;
					9'd7:    nb = sp_on ? sv : 8'd0;
					9'd9:    nb = sp_on ? harp_pkg::FLAGS_SPK : 8'd0;
					default: nb = byte_value;
				endcase
			end
		end else if (base == harp_pkg::ID_LATENCY && plen_q >= 8'd6) begin
			if (off_q >= 9'd3 && off_q <= {1'b0, plen_q}) nb = lat;
		end else if (!autom && base == harp_pkg::ID_HAPTIC && plen_q >= 8'd2 &&
		             haptic_gain_q != harp_pkg::GAIN_UNITY) begin
			nb = harp_pkg::scale_sample(byte_value, haptic_gain_q);
		end
	end

	always_comb begin
		patchable_n = patchable_q;
		stopped_n   = stopped_q;
		off_n       = off_q;
		blen_n      = blen_q;
		id_n        = id_q;
		plen_n      = plen_q;
		changed_n   = changed_q;
		b_n         = byte_value;
		held_out    = held_byte_q;
		if (pos_q == '0) begin
			patchable_n = (report_length >= 11'd12) &&
			              (13'(report_length) <= 13'(harp_pkg::MAX_REPORT_BYTES)) &&
			              (byte_value == harp_pkg::TYPE_A || byte_value == harp_pkg::TYPE_B ||
			               byte_value == harp_pkg::TYPE_C);
			stopped_n   = 1'b0;
			off_n       = '0;
			blen_n      = '0;
			id_n        = '0;
			plen_n      = '0;
			changed_n   = 1'b0;
		end else if (patchable_q && !stopped_q && pos_q >= 12'd2) begin
			case (off_q)
				9'd0: begin
					if (pos13 + 13'd2 > limit13) begin
						stopped_n = 1'b1;
					end else begin
						id_n  = byte_value;
						off_n = 9'd1;
					end
				end
				9'd1: begin
					plen_n = byte_value;
					if (id_q == 8'd0 && byte_value == 8'd0) begin
						stopped_n = 1'b1;
					end else if (pos13 + 13'(blen) - 13'd1 > limit13) begin
						stopped_n = 1'b1;
					end else begin
						blen_n = blen;
						if (!autom && route != 8'd0 && held_valid_q &&
						    base >= harp_pkg::ROUTE_SPEAKER &&
						    base <= harp_pkg::ROUTE_HEADSET &&
						    held_byte_q != routed) begin
							held_out  = routed;
							changed_n = 1'b1;
						end
						off_n = (blen > 10'd2) ? 9'd2 : 9'd0;
					end
				end
				default: begin
					b_n = nb;
					if (nb != byte_value) changed_n = 1'b1;
					off_n = (10'(off_q) + 10'd1 >= blen_q) ? 9'd0 : off_q + 9'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			pos_q        <= '0;
			patchable_q  <= 1'b0;
			stopped_q    <= 1'b0;
			off_q        <= '0;
			blen_q       <= '0;
			id_q         <= '0;
			plen_q       <= '0;
			changed_q    <= 1'b0;
		end else if (accept) begin
			patchable_q <= patchable_n;
			stopped_q   <= stopped_n;
			off_q       <= off_n;
			blen_q      <= blen_n;
			id_q        <= id_n;
			plen_q      <= plen_n;
			changed_q   <= changed_n;
			if (last_byte) begin
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				pos_q        <= '0;
			end else begin
				held_byte_q  <= b_n;
				held_valid_q <= 1'b1;
				if (pos_q != '1) pos_q <= pos_q + 12'd1;
			end
		end
	end

	always_comb begin
		push.en0        = accept && held_valid_q;
		push.w0.data    = held_out;
		push.w0.last    = 1'b0;
		push.w0.changed = 1'b0;
		push.en1        = accept && last_byte;
		push.w1.data    = b_n;
		push.w1.last    = 1'b1;
		push.w1.changed = changed_n;
	end

	harp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign byte_out       = head.data;
	assign last_out       = head.last;
	assign report_changed = head.changed;

endmodule

[hw/rtl/harp_out_fifo.sv]
// Four-entry output word queue, up to two pushes and one pop per cycle.
module harp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  harp_pkg::harp_push_t push,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output harp_pkg::harp_word_t head
);

	harp_pkg::harp_word_t                mem_q [harp_pkg::FIFO_DEPTH];
	logic [harp_pkg::PTR_W-1:0]          wr_ptr_q;
	logic [harp_pkg::PTR_W-1:0]          rd_ptr_q;
	logic [harp_pkg::CNT_W-1:0]          count_q;
	logic                                pop;
	logic [1:0]                          n_push;
	harp_pkg::harp_word_t                first_w;

	assign space     = count_q <= harp_pkg::CNT_W'(harp_pkg::FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = 2'(push.en0) + 2'(push.en1);
	assign first_w   = push.en0 ? push.w0 : push.w1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= first_w;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + harp_pkg::PTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + harp_pkg::PTR_W'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + harp_pkg::PTR_W'(1);
			count_q <= count_q + harp_pkg::CNT_W'(n_push) - harp_pkg::CNT_W'(pop);
		end
	end

endmodule

[hw/rtl/harp_checker.sv]
// Port-level checks for the report patcher, bound to the top level.
module harp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic       last_out,
	input logic       report_changed
);

	// bytes taken but not yet delivered
	logic [3:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
		end
	end

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(last_out))
		else $error("output word changed while stalled");

	a_changed_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> !report_changed)
		else $error("changed flag on a word that is not last");

	a_no_invented_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("output word with no byte taken");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5)
		else $error("more bytes in flight than the queue and holding byte allow");

endmodule

bind hid_audio_report_patcher harp_checker u_harp_checker (.*);
